>>> hw/rtl/srg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shuffled random generator.
package srg_pkg;

  localparam logic [14:0] LCG_MUL = 15'd16807;
  localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam int          RECIP_SHIFT = 37;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN_MUL,
    ST_RUN_FOLD,
    ST_FIX_A,
    ST_FIX_B,
    ST_MUL,
    ST_FOLD,
    ST_SLOT_A,
    ST_SLOT_B
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic cnt_load;
    logic step;
    logic fill;
    logic req;
    logic slot_load;
  } cmd_t;

  typedef struct packed {
    logic fresh;
    logic cnt_zero;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/srg_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module srg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/srg_datapath.sv
`timescale 1ns / 1ps
// Datapath: generator, shuffle table, slot divider and output register.
module srg_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  srg_pkg::cmd_t      cmd,
  output srg_pkg::stat_t     stat,
  input  logic               in_reseed,
  input  logic [30:0]        in_seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_value,
  output logic [4:0]         out_slot
);

  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 8);
  localparam int QW = SW + 1;
  localparam logic [31:0] SLOT_DIV =
    32'(64'd1 + (64'd2147483646 / 64'(TABLE_DEPTH)));
  localparam logic [63:0] RECIP = (64'd1 << srg_pkg::RECIP_SHIFT) / 64'(SLOT_DIV);
  localparam int PW = srg_pkg::RECIP_SHIFT + QW;

  logic [30:0]     gen;
  logic [45:0]     prod;
  logic [30:0]     last_output;
  logic [PW-1:0]   qp;
  logic [SW-1:0]   slot;
  logic [CW-1:0]   cnt;

  logic [31:0]     fold_sum;
  logic [30:0]     gen_next;
  logic [30:0]     seed_pick;
  logic [QW-1:0]   q_est;
  logic [QW-1:0]   q_fix;
  logic [QW+31:0]  thr;
  logic [SW-1:0]   slot_next;
  logic            fill_we;
  logic            ram_we;
  logic [SW-1:0]   waddr;
  logic [30:0]     rdata;

  // x*16807 mod 2^31-1 by folding the high part onto the low part
  assign fold_sum = {1'b0, prod[30:0]} + 32'(prod[45:31]);
  assign gen_next = (fold_sum >= {1'b0, srg_pkg::LCG_MOD}) ?
                    31'(fold_sum - {1'b0, srg_pkg::LCG_MOD}) : fold_sum[30:0];

  assign seed_pick = !in_reseed ? 31'd1 : ((in_seed == '0) ? 31'd1 : in_seed);

  // slot = last_output / SLOT_DIV: reciprocal estimate plus one correction, clamped to TABLE_DEPTH-1
  assign q_est = qp[srg_pkg::RECIP_SHIFT +: QW];
  assign thr   = (QW+32)'(q_est + QW'(1)) * (QW+32)'(SLOT_DIV);
  assign q_fix = ((QW+32)'(last_output) >= thr) ? q_est + QW'(1) : q_est;
  assign slot_next = (q_fix > QW'(TABLE_DEPTH - 1)) ? SW'(TABLE_DEPTH - 1) : q_fix[SW-1:0];

  assign fill_we = cmd.fill && (cnt < CW'(TABLE_DEPTH));
  assign ram_we  = fill_we || cmd.req;
  assign waddr   = cmd.fill ? cnt[SW-1:0] : slot;

  srg_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (gen_next),
    .raddr (slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    prod <= 46'(gen) * 46'(srg_pkg::LCG_MUL);
    qp   <= PW'(last_output) * PW'(RECIP);
    if (cmd.slot_load) begin
      slot <= slot_next;
    end
    if (cmd.cnt_load) begin
      cnt <= CW'(TABLE_DEPTH + 7);
    end else if (cmd.fill && (cnt != '0)) begin
      cnt <= cnt - CW'(1);
    end
    if (cmd.req) begin
      out_value <= rdata;
      out_slot  <= 5'(slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen         <= 31'd1;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        gen <= seed_pick;
      end else if (cmd.step) begin
        gen <= gen_next;
      end
      if (fill_we) begin
        last_output <= gen_next;
      end else if (cmd.req) begin
        last_output <= rdata;
      end
      if (cmd.req) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.fresh    = in_reseed || (last_output == '0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.out_free = !out_valid || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.req && out_valid |-> out_ready)
    else $error("output beat overwritten while stalled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.slot_load |=> slot <= SW'(TABLE_DEPTH - 1))
    else $error("slot beyond table depth");

  a_gen_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> gen != srg_pkg::LCG_MOD)
    else $error("generator value not reduced");

endmodule

>>> hw/rtl/srg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for request handling and table refill runs.
module srg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  srg_pkg::stat_t  stat,
  output srg_pkg::cmd_t   cmd
);

  srg_pkg::state_t state;
  srg_pkg::state_t state_next;
  logic            take;

  assign take = in_ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srg_pkg::ST_IDLE,
      srg_pkg::ST_SLOT_B: begin
        if (in_valid) begin
          state_next = stat.fresh ? srg_pkg::ST_RUN_MUL : srg_pkg::ST_MUL;
        end else begin
          state_next = srg_pkg::ST_IDLE;
        end
      end
      srg_pkg::ST_RUN_MUL:  state_next = srg_pkg::ST_RUN_FOLD;
      srg_pkg::ST_RUN_FOLD: begin
        state_next = stat.cnt_zero ? srg_pkg::ST_FIX_A : srg_pkg::ST_RUN_MUL;
      end
      srg_pkg::ST_FIX_A:    state_next = srg_pkg::ST_FIX_B;
      srg_pkg::ST_FIX_B:    state_next = srg_pkg::ST_MUL;
      srg_pkg::ST_MUL: begin
        if (stat.out_free) begin
          state_next = srg_pkg::ST_FOLD;
        end
      end
      srg_pkg::ST_FOLD:     state_next = srg_pkg::ST_SLOT_A;
      srg_pkg::ST_SLOT_A:   state_next = srg_pkg::ST_SLOT_B;
      default:              state_next = srg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      srg_pkg::ST_IDLE: begin
        in_ready = !rst;
      end
      srg_pkg::ST_SLOT_B: begin
        in_ready      = !rst;
        cmd.slot_load = 1'b1;
      end
      srg_pkg::ST_FIX_B: begin
        cmd.slot_load = 1'b1;
      end
      srg_pkg::ST_RUN_FOLD: begin
        cmd.step = 1'b1;
        cmd.fill = 1'b1;
      end
      srg_pkg::ST_FOLD: begin
        cmd.step = 1'b1;
        cmd.req  = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load_seed = take && stat.fresh;
    cmd.cnt_load  = take && stat.fresh;
  end

endmodule

>>> hw/rtl/shuffled_lcg_random_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the shuffled minimal-standard random generator.
//
// Each beat on the s_axis channel requests one random integer; each beat on
// m_axis returns it with the shuffle table slot it came from. Divide the value
// by 2^31-1 for a uniform fraction.
// A request with tuser (reseed) set, or the first request after reset, first
// refills the table: TABLE_DEPTH+8 generator steps, each a multiply state and
// a fold state, then the slot division states FIX_A and FIX_B.
// Normal request: multiply, then fold and table update, which registers the
// result, then the reciprocal slot divider states SLOT_A and SLOT_B; the
// next request is accepted no earlier than SLOT_B, so requests do not overlap.
// One output register holds a finished result; if the receiver stalls, the
// next request is accepted and waits before its table update until the output
// register is free.
// Reset (synchronous, active high) sets the generator to 1 and marks the
// table empty, so the first request always refills. The table RAM needs no
// clearing pass.
module shuffled_lcg_random_generator_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] seed_magnitude, [31] zero
  input  logic        s_axis_tuser,   // [0] reseed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [30:0] random_value, [35:31] table_slot, zero above
);

  srg_pkg::cmd_t  cmd;
  srg_pkg::stat_t stat;
  logic [30:0]    out_value;
  logic [4:0]     out_slot;

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srg_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_reseed (s_axis_tuser),
    .in_seed   (s_axis_tdata[30:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_slot  (out_slot)
  );

  assign m_axis_tdata = {4'b0000, out_slot, out_value};

endmodule
